FILE: rtl/bm3_pkg.sv
// ----------------------------------------------------------------------------
// bm3_pkg
// Shared constants for the streaming 3x3 binary morphology block: mode codes,
// register indexes, operation codes, mask codes, pixel levels and reset values.
// ----------------------------------------------------------------------------
`default_nettype none

package bm3_pkg;

  localparam int unsigned PIX_W  = 8;
  localparam int unsigned MODE_W = 3;
  localparam int unsigned MASK_W = 18;
  localparam int unsigned SIZE_W = 11;

  localparam logic [MODE_W-1:0] MODE_ERODE    = 3'd0;
  localparam logic [MODE_W-1:0] MODE_DILATE   = 3'd1;
  localparam logic [MODE_W-1:0] MODE_HIT_MISS = 3'd2;
  localparam logic [MODE_W-1:0] MODE_OUTER    = 3'd3;
  localparam logic [MODE_W-1:0] MODE_INNER    = 3'd4;
  localparam logic [MODE_W-1:0] MODE_GRADIENT = 3'd5;

  localparam logic [1:0] REG_MODE   = 2'd0;
  localparam logic [1:0] REG_MASK   = 2'd1;
  localparam logic [1:0] REG_WIDTH  = 2'd2;
  localparam logic [1:0] REG_HEIGHT = 2'd3;

  localparam logic OP_PIXEL = 1'b0;
  localparam logic OP_DRAIN = 1'b1;

  localparam logic [1:0] CODE_BG = 2'd0;
  localparam logic [1:0] CODE_FG = 2'd1;

  localparam logic [PIX_W-1:0] PIX_FG = 8'd255;
  localparam logic [PIX_W-1:0] PIX_BG = 8'd0;

  localparam logic [MODE_W-1:0] RST_MODE   = 3'd0;
  localparam logic [MASK_W-1:0] RST_MASK   = 18'h15555;
  localparam logic [SIZE_W-1:0] RST_WIDTH  = 11'd640;
  localparam logic [SIZE_W-1:0] RST_HEIGHT = 11'd480;

endpackage

`default_nettype wire

FILE: rtl/bm3_line_mem.sv
// ----------------------------------------------------------------------------
// bm3_line_mem
// Line buffer memory: one write port, one read port with registered data.
// Each word holds the two previous rows of one column.
// ----------------------------------------------------------------------------
`default_nettype none

module bm3_line_mem #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10,
  parameter int unsigned DW    = 16
) (
  input  wire logic          clk_i,
  input  wire logic          we_i,
  input  wire logic [AW-1:0] waddr_i,
  input  wire logic [DW-1:0] wdata_i,
  input  wire logic          re_i,
  input  wire logic [AW-1:0] raddr_i,
  output      logic [DW-1:0] rdata_o
);

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

FILE: rtl/binary_morphology_3x3.sv
// ----------------------------------------------------------------------------
// binary_morphology_3x3
// Streaming 3x3 binary morphology (erosion, dilation, hit-or-miss, outer and
// inner boundary, gradient) on raster frames with two line buffers and a
// 3x3 window. A drain transaction flushes the results still owed.
// Throughput: one transaction per cycle while the output is not stalled.
// Pipeline: an accepted transaction is registered in the stage 1 register and
// line buffer read, then its window result is registered in the output register.
// Results trail the input by one row and one pixel; the first W+1 pixels give
// none. Reset clears counters, window, flush state and registers to their
// defaults; line buffer contents are left as they are, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module binary_morphology_3x3 #(
  parameter int unsigned MAX_WIDTH  = 1024,
  parameter int unsigned MAX_HEIGHT = 1024
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,

  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [3:0]  paddr,
  input  wire logic [31:0] pwdata,
  output      logic [31:0] prdata,
  output      logic        pready,

  input  wire logic        in_valid_i,
  output      logic        in_stall_o,
  input  wire logic        operation_i,
  input  wire logic [7:0]  pixel_in_i,

  output      logic        out_valid_o,
  input  wire logic        out_stall_i,
  output      logic [7:0]  pixel_out_o,
  output      logic        frame_end_o
);

  localparam int unsigned WB  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned HB  = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned CAW = $clog2(MAX_WIDTH);
  localparam int unsigned RAW = $clog2(MAX_HEIGHT);
  localparam int unsigned PW  = $clog2(MAX_WIDTH + 2);
  localparam int unsigned XW  = WB + 2;
  localparam int unsigned YW  = HB + 2;
  localparam int unsigned PXW = bm3_pkg::PIX_W;

  // --------------------------------------------------------------------------
  // Configuration registers
  // --------------------------------------------------------------------------
  logic [bm3_pkg::MODE_W-1:0] mode_q;
  logic [bm3_pkg::MASK_W-1:0] mask_q;
  logic [bm3_pkg::SIZE_W-1:0] width_q;
  logic [bm3_pkg::SIZE_W-1:0] height_q;
  logic                       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= bm3_pkg::RST_MODE;
      mask_q   <= bm3_pkg::RST_MASK;
      width_q  <= bm3_pkg::RST_WIDTH;
      height_q <= bm3_pkg::RST_HEIGHT;
    end else if (cfg_wr) begin
      unique case (paddr[3:2])
        bm3_pkg::REG_MODE:   mode_q   <= pwdata[bm3_pkg::MODE_W-1:0];
        bm3_pkg::REG_MASK:   mask_q   <= pwdata[bm3_pkg::MASK_W-1:0];
        bm3_pkg::REG_WIDTH:  width_q  <= pwdata[bm3_pkg::SIZE_W-1:0];
        bm3_pkg::REG_HEIGHT: height_q <= pwdata[bm3_pkg::SIZE_W-1:0];
        default:             mode_q   <= mode_q;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      bm3_pkg::REG_MODE:   prdata = 32'(mode_q);
      bm3_pkg::REG_MASK:   prdata = 32'(mask_q);
      bm3_pkg::REG_WIDTH:  prdata = 32'(width_q);
      bm3_pkg::REG_HEIGHT: prdata = 32'(height_q);
      default:             prdata = '0;
    endcase
  end

  // --------------------------------------------------------------------------
  // Clamped frame size
  // --------------------------------------------------------------------------
  logic [WB-1:0] w_c;
  logic [HB-1:0] h_c;

  always_comb begin
    if (width_q < bm3_pkg::SIZE_W'(3)) begin
      w_c = WB'(3);
    end else if (32'(width_q) > MAX_WIDTH) begin
      w_c = WB'(MAX_WIDTH);
    end else begin
      w_c = WB'(width_q);
    end
    if (height_q < bm3_pkg::SIZE_W'(3)) begin
      h_c = HB'(3);
    end else if (32'(height_q) > MAX_HEIGHT) begin
      h_c = HB'(MAX_HEIGHT);
    end else begin
      h_c = HB'(height_q);
    end
  end

  // --------------------------------------------------------------------------
  // Position counters and flush control
  // --------------------------------------------------------------------------
  logic [CAW-1:0] col_q, col_d, col_e;
  logic [RAW-1:0] row_q, row_d, row_e;
  logic [PW-1:0]  pend_q, pend_d, pend_e, pend_base, wp1;
  logic           flush_q, flush_d;
  logic           in_acc, is_pixel, primed, ins, emit;
  logic [CAW:0]   col_inc;
  logic [RAW:0]   row_inc;
  logic [CAW-1:0] col_adv;
  logic [RAW-1:0] row_adv;

  logic signed [XW-1:0] px, pxm, pxp, w_s;
  logic signed [YW-1:0] py0, py, pym, pyp, h_s;
  logic [2:0]           xin, yin;
  logic                 fend;

  // Stage 1 (window stage) registers
  logic           s1_valid_q, s1_emit_q, s1_end_q, s1_adv;
  logic [PXW-1:0] s1_pix_q;
  logic [CAW-1:0] s1_addr_q;
  logic [2:0]     s1_xin_q, s1_yin_q;
  logic           fwd_sel_q;
  logic [2*PXW-1:0] fwd_q, mem_wdata, mem_rdata, rd;

  logic           out_valid_q;
  logic [PXW-1:0] pixel_out_q;
  logic           frame_end_q;

  assign s1_adv     = s1_valid_q & (~s1_emit_q | ~out_valid_q | ~out_stall_i);
  assign in_stall_o = s1_valid_q & ~s1_adv;
  assign in_acc     = in_valid_i & ~in_stall_o;
  assign is_pixel   = (operation_i == bm3_pkg::OP_PIXEL);

  always_comb begin
    if (is_pixel && flush_q) begin
      col_e  = '0;
      row_e  = '0;
      pend_e = '0;
    end else begin
      col_e  = col_q;
      row_e  = row_q;
      pend_e = pend_q;
    end
    wp1     = PW'(w_c) + PW'(1);
    primed  = (pend_e >= wp1);
    ins     = is_pixel | flush_q | primed;
    emit    = is_pixel ? primed : ins;

    col_inc = (CAW+1)'(col_e) + (CAW+1)'(1);
    row_inc = (RAW+1)'(row_e) + (RAW+1)'(1);
    if (col_inc >= (CAW+1)'(w_c)) begin
      col_adv = '0;
      if (row_inc >= (RAW+1)'(h_c)) begin
        row_adv = '0;
      end else begin
        row_adv = row_inc[RAW-1:0];
      end
    end else begin
      col_adv = col_inc[CAW-1:0];
      row_adv = row_e;
    end

    pend_base = flush_q ? pend_q : wp1;
    col_d     = col_q;
    row_d     = row_q;
    pend_d    = pend_q;
    flush_d   = flush_q;
    if (in_acc) begin
      if (is_pixel) begin
        col_d   = col_adv;
        row_d   = row_adv;
        pend_d  = primed ? wp1 : pend_e + PW'(1);
        flush_d = 1'b0;
      end else if (ins) begin
        pend_d = pend_base - PW'(1);
        if (pend_d == '0) begin
          flush_d = 1'b0;
          col_d   = '0;
          row_d   = '0;
        end else begin
          flush_d = 1'b1;
          col_d   = col_adv;
          row_d   = row_adv;
        end
      end
    end
  end

  // Result position and interior flags for the window centre
  always_comb begin
    w_s = $signed(XW'(w_c));
    h_s = $signed(YW'(h_c));
    if (col_e != '0) begin
      px  = $signed(XW'(col_e)) - XW'(1);
      py0 = $signed(YW'(row_e)) - YW'(1);
    end else begin
      px  = w_s - XW'(1);
      py0 = $signed(YW'(row_e)) - YW'(2);
    end
    py  = (py0 < 0) ? py0 + h_s : py0;
    pxm = px - XW'(1);
    pxp = px + XW'(1);
    pym = py - YW'(1);
    pyp = py + YW'(1);
    xin[0] = (pxm >= XW'(1)) && (pxm <= w_s - XW'(2));
    xin[1] = (px  >= XW'(1)) && (px  <= w_s - XW'(2));
    xin[2] = (pxp >= XW'(1)) && (pxp <= w_s - XW'(2));
    yin[0] = (pym >= YW'(1)) && (pym <= h_s - YW'(2));
    yin[1] = (py  >= YW'(1)) && (py  <= h_s - YW'(2));
    yin[2] = (pyp >= YW'(1)) && (pyp <= h_s - YW'(2));
    fend   = (px == w_s - XW'(1)) && (py == h_s - YW'(1));
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      col_q   <= '0;
      row_q   <= '0;
      pend_q  <= '0;
      flush_q <= 1'b0;
    end else begin
      col_q   <= col_d;
      row_q   <= row_d;
      pend_q  <= pend_d;
      flush_q <= flush_d;
    end
  end

  // --------------------------------------------------------------------------
  // Stage 1 register and line buffer
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= (in_acc & ins) | (s1_valid_q & ~s1_adv);
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc && ins) begin
      s1_emit_q <= emit;
      s1_end_q  <= fend;
      s1_pix_q  <= is_pixel ? pixel_in_i : bm3_pkg::PIX_BG;
      s1_addr_q <= col_e;
      s1_xin_q  <= xin;
      s1_yin_q  <= yin;
      fwd_sel_q <= s1_adv && (s1_addr_q == col_e);
      fwd_q     <= mem_wdata;
    end
  end

  assign rd        = fwd_sel_q ? fwd_q : mem_rdata;
  assign mem_wdata = {rd[PXW-1:0], s1_pix_q};

  bm3_line_mem #(
    .DEPTH (MAX_WIDTH),
    .AW    (CAW),
    .DW    (2*PXW)
  ) u_line_mem (
    .clk_i   (clk_i),
    .we_i    (s1_adv),
    .waddr_i (s1_addr_q),
    .wdata_i (mem_wdata),
    .re_i    (in_acc & ins),
    .raddr_i (col_e),
    .rdata_o (mem_rdata)
  );

  // --------------------------------------------------------------------------
  // Window and morphology
  // --------------------------------------------------------------------------
  logic [PXW-1:0] win_q [3][3];
  logic [PXW-1:0] win_n [3][3];
  logic [PXW-1:0] centre, ero, hm, dil, res;
  logic           ero_hit, hm_miss, dil_hit;

  always_comb begin
    for (int r = 0; r < 3; r++) begin
      win_n[r][0] = win_q[r][1];
      win_n[r][1] = win_q[r][2];
    end
    win_n[0][2] = rd[2*PXW-1:PXW];
    win_n[1][2] = rd[PXW-1:0];
    win_n[2][2] = s1_pix_q;
  end

  always_comb begin
    centre  = win_n[1][1];
    ero_hit = 1'b0;
    hm_miss = 1'b0;
    dil_hit = 1'b0;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (mask_q[2*(3*r+c) +: 2] == bm3_pkg::CODE_FG) begin
          if (win_n[r][c] == bm3_pkg::PIX_BG) ero_hit = 1'b1;
          if (win_n[r][c] != bm3_pkg::PIX_FG) hm_miss = 1'b1;
        end
        if (mask_q[2*(3*r+c) +: 2] == bm3_pkg::CODE_BG) begin
          if (win_n[r][c] != bm3_pkg::PIX_BG) hm_miss = 1'b1;
        end
        if ((win_n[r][c] == bm3_pkg::PIX_FG) &&
            (mask_q[2*(8-3*r-c) +: 2] == bm3_pkg::CODE_FG) &&
            s1_yin_q[r] && s1_xin_q[c]) begin
          dil_hit = 1'b1;
        end
      end
    end
    if (s1_xin_q[1] && s1_yin_q[1]) begin
      ero = ero_hit ? bm3_pkg::PIX_BG : bm3_pkg::PIX_FG;
      hm  = hm_miss ? bm3_pkg::PIX_BG : bm3_pkg::PIX_FG;
    end else begin
      ero = centre;
      hm  = centre;
    end
    dil = ((mask_q[9:8] == bm3_pkg::CODE_FG) && dil_hit) ? bm3_pkg::PIX_FG : bm3_pkg::PIX_BG;
    unique case (mode_q)
      bm3_pkg::MODE_DILATE:   res = dil;
      bm3_pkg::MODE_HIT_MISS: res = hm;
      bm3_pkg::MODE_OUTER:    res = (centre == bm3_pkg::PIX_FG) ? bm3_pkg::PIX_BG : dil;
      bm3_pkg::MODE_INNER:    res = (ero == bm3_pkg::PIX_FG) ? bm3_pkg::PIX_BG : centre;
      bm3_pkg::MODE_GRADIENT: res = (ero == bm3_pkg::PIX_FG) ? bm3_pkg::PIX_BG : dil;
      default:                res = ero;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 3; c++) begin
          win_q[r][c] <= '0;
        end
      end
    end else if (s1_adv) begin
      win_q <= win_n;
    end
  end

  // --------------------------------------------------------------------------
  // Output register
  // --------------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= (s1_adv & s1_emit_q) | (out_valid_q & out_stall_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_adv && s1_emit_q) begin
      pixel_out_q <= res;
      frame_end_q <= s1_end_q;
    end
  end

  assign out_valid_o = out_valid_q;
  assign pixel_out_o = pixel_out_q;
  assign frame_end_o = frame_end_q;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_flush_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    flush_q |-> (pend_q != '0))
    else $error("flush active with nothing pending");

  a_stall_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> (s1_valid_q && s1_emit_q && out_valid_q))
    else $error("input stalled without a blocked result");

  a_emit_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_adv && s1_emit_q) |=> out_valid_q)
    else $error("emitted result lost");

  a_s1_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_adv) |=> (s1_valid_q && $stable(s1_addr_q) && $stable(s1_pix_q)))
    else $error("window stage changed while held");

endmodule

`default_nettype wire

FILE: tb/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: binary_morphology_3x3 testbench
// Streams raster pixels and drain transactions into the 3x3 morphology block
// and predicts every output pixel and frame_end flag with a cycle-free model
// of the line buffers, window and flush logic. The APB port sets mode, mask
// and frame size between phases and is read back. Random idle bursts on both
// channels and one long output hold-off exercise backpressure.
// ----------------------------------------------------------------------------
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import bm3_pkg::*;

  localparam int MAX_W       = 1024;
  localparam int MAX_H       = 1024;
  localparam int ITEMS_GOAL  = 1300;
  localparam int HOLD_CYCLES = 400;
  localparam int STUCK_LIMIT = 2000;

  typedef struct packed {
    logic       op;
    logic [7:0] pix;
  } raster_item_t;

  typedef struct packed {
    logic [7:0] pix;
    logic       fend;
  } morph_out_t;

  logic        clk_i       = 1'b0;
  logic        rst_ni      = 1'b0;
  logic        psel        = 1'b0;
  logic        penable     = 1'b0;
  logic        pwrite      = 1'b0;
  logic [3:0]  paddr       = '0;
  logic [31:0] pwdata      = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid_i  = 1'b0;
  logic        in_stall_o;
  logic        operation_i = OP_PIXEL;
  logic [7:0]  pixel_in_i  = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b0;
  logic [7:0]  pixel_out_o;
  logic        frame_end_o;

  raster_item_t raster_q[$];
  morph_out_t   due_pixels[$];
  raster_item_t next_item;

  logic [MODE_W-1:0] cur_mode  = RST_MODE;
  logic [MASK_W-1:0] cur_mask  = RST_MASK;
  logic [SIZE_W-1:0] cur_w_reg = RST_WIDTH;
  logic [SIZE_W-1:0] cur_h_reg = RST_HEIGHT;

  logic [7:0] row_old [MAX_W];
  logic [7:0] row_new [MAX_W];
  logic [7:0] win [3][3];
  int         col_pos = 0;
  int         row_pos = 0;
  int         owed    = 0;
  bit         flush_on = 1'b0;

  int  errors       = 0;
  int  items_queued = 0;
  int  fg_pct       = 50;
  bit  no_idle      = 1'b0;
  bit  hold_req     = 1'b0;
  bit  hold_done    = 1'b0;
  int  hold_left    = 0;
  int  stall_left   = 0;
  int  send_gap     = 0;
  int  quiet_cycles = 0;
  logic in_taken    = 1'b0;

  binary_morphology_3x3 #(
    .MAX_WIDTH (MAX_W),
    .MAX_HEIGHT(MAX_H)
  ) uut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .psel       (psel),
    .penable    (penable),
    .pwrite     (pwrite),
    .paddr      (paddr),
    .pwdata     (pwdata),
    .prdata     (prdata),
    .pready     (pready),
    .in_valid_i (in_valid_i),
    .in_stall_o (in_stall_o),
    .operation_i(operation_i),
    .pixel_in_i (pixel_in_i),
    .out_valid_o(out_valid_o),
    .out_stall_i(out_stall_i),
    .pixel_out_o(pixel_out_o),
    .frame_end_o(frame_end_o)
  );

  always #4 clk_i = ~clk_i;

  function automatic void flag_error(string msg);
    errors++;
    if (errors <= 10) begin
      $display("ERROR: %s", msg);
    end
  endfunction

  function automatic int eff_size(logic [SIZE_W-1:0] r, int top);
    if (r < 3) return 3;
    if (r > top) return top;
    return int'(r);
  endfunction

  function automatic logic [1:0] code_at(int i);
    return cur_mask[2*i +: 2];
  endfunction

  function automatic bit interior(int x, int y, int w, int h);
    return x >= 1 && x <= w - 2 && y >= 1 && y <= h - 2;
  endfunction

  function automatic logic [7:0] erode_at(bit inner, logic [7:0] centre);
    if (!inner) return centre;
    for (int i = 0; i < 9; i++) begin
      if (code_at(i) == CODE_FG && win[i/3][i%3] == PIX_BG) return PIX_BG;
    end
    return PIX_FG;
  endfunction

  function automatic logic [7:0] hit_miss_at(bit inner, logic [7:0] centre);
    logic [1:0] k;
    logic [7:0] v;
    if (!inner) return centre;
    for (int i = 0; i < 9; i++) begin
      k = code_at(i);
      v = win[i/3][i%3];
      if (k == CODE_FG && v != PIX_FG) return PIX_BG;
      if (k == CODE_BG && v != PIX_BG) return PIX_BG;
    end
    return PIX_FG;
  endfunction

  function automatic logic [7:0] dilate_at(int px, int py, int w, int h);
    if (code_at(4) != CODE_FG) return PIX_BG;
    for (int r = 0; r < 3; r++) begin
      for (int c = 0; c < 3; c++) begin
        if (win[r][c] == PIX_FG && code_at(8 - 3*r - c) == CODE_FG &&
            interior(px + c - 1, py + r - 1, w, h)) return PIX_FG;
      end
    end
    return PIX_BG;
  endfunction

  function automatic void shift_in(logic [7:0] v);
    int         c;
    logic [7:0] top;
    logic [7:0] mid;
    c = col_pos % MAX_W;
    top = row_old[c];
    mid = row_new[c];
    row_old[c] = mid;
    row_new[c] = v;
    for (int r = 0; r < 3; r++) begin
      win[r][0] = win[r][1];
      win[r][1] = win[r][2];
    end
    win[0][2] = top;
    win[1][2] = mid;
    win[2][2] = v;
  endfunction

  function automatic void advance(int w, int h);
    col_pos++;
    if (col_pos >= w) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= h) row_pos = 0;
    end
  endfunction

  function automatic morph_out_t window_result(int w, int h);
    int         px;
    int         py;
    bit         inner;
    logic [7:0] centre;
    logic [7:0] ero;
    logic [7:0] val;
    morph_out_t res;
    centre = win[1][1];
    if (col_pos >= 1) begin
      px = col_pos - 1;
      py = row_pos - 1;
    end else begin
      px = w - 1;
      py = row_pos - 2;
    end
    if (py < 0) py += h;
    inner = interior(px, py, w, h);
    ero = erode_at(inner, centre);
    case (cur_mode)
      MODE_DILATE:   val = dilate_at(px, py, w, h);
      MODE_HIT_MISS: val = hit_miss_at(inner, centre);
      MODE_OUTER:    val = (centre == PIX_FG) ? PIX_BG : dilate_at(px, py, w, h);
      MODE_INNER:    val = (ero == PIX_FG) ? PIX_BG : centre;
      MODE_GRADIENT: val = (ero == PIX_FG) ? PIX_BG : dilate_at(px, py, w, h);
      default:       val = ero;
    endcase
    res.pix  = val;
    res.fend = (px == w - 1 && py == h - 1);
    return res;
  endfunction

  function automatic void morph_step(logic op, logic [7:0] pix);
    int w;
    int h;
    bit emit;
    w = eff_size(cur_w_reg, MAX_W);
    h = eff_size(cur_h_reg, MAX_H);
    if (op == OP_PIXEL) begin
      if (flush_on) begin
        flush_on = 1'b0;
        owed = 0;
        col_pos = 0;
        row_pos = 0;
      end
      emit = owed >= w + 1;
      if (emit) owed = w + 1;
      else owed++;
      shift_in(pix);
      if (emit) due_pixels.push_back(window_result(w, h));
      advance(w, h);
    end else begin
      if (!flush_on) begin
        if (owed < w + 1) return;
        flush_on = 1'b1;
        owed = w + 1;
      end
      shift_in(PIX_BG);
      due_pixels.push_back(window_result(w, h));
      advance(w, h);
      owed--;
      if (owed == 0) begin
        flush_on = 1'b0;
        col_pos = 0;
        row_pos = 0;
      end
    end
  endfunction

  function automatic logic [7:0] rand_pix();
    if ($urandom_range(0, 15) == 0) return 8'($urandom_range(0, 255));
    return ($urandom_range(1, 100) <= fg_pct) ? PIX_FG : PIX_BG;
  endfunction

  function automatic void push_item(logic op, logic [7:0] pix);
    raster_item_t it;
    it.op  = op;
    it.pix = pix;
    raster_q.push_back(it);
    items_queued++;
  endfunction

  task automatic wait_idle();
    @(posedge clk_i);
    while (raster_q.size() != 0 || in_valid_i || due_pixels.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  task automatic reg_read_check(logic [1:0] idx, logic [31:0] want);
    logic [31:0] keep;
    logic [31:0] got;
    case (idx)
      REG_MODE:  keep = 32'h7;
      REG_MASK:  keep = 32'h3FFFF;
      default:   keep = 32'h7FF;
    endcase
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    paddr   <= {idx, 2'b00};
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    got = prdata;
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    if ((got & keep) !== (want & keep)) begin
      flag_error($sformatf("register %0d read expected 0x%0h got 0x%0h",
                           idx, want & keep, got & keep));
    end
  endtask

  task automatic reg_set(logic [1:0] idx, logic [31:0] val);
    @(negedge clk_i);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {idx, 2'b00};
    pwdata  <= val;
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    @(negedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    case (idx)
      REG_MODE:  cur_mode  = val[MODE_W-1:0];
      REG_MASK:  cur_mask  = val[MASK_W-1:0];
      REG_WIDTH: cur_w_reg = val[SIZE_W-1:0];
      default:   cur_h_reg = val[SIZE_W-1:0];
    endcase
    reg_read_check(idx, val);
  endtask

  task automatic settle(bit flush);
    int w;
    int extra;
    wait_idle();
    if (flush) begin
      w = eff_size(cur_w_reg, MAX_W);
      if (flush_on) begin
        extra = owed;
      end else begin
        for (int i = owed; i < w + 1; i++) push_item(OP_PIXEL, rand_pix());
        extra = w + 1;
      end
      repeat (extra) push_item(OP_DRAIN, 8'($urandom_range(0, 255)));
      wait_idle();
    end
    repeat (8) @(posedge clk_i);
  endtask

  // Input driver: hold the payload until accepted, then advance.
  always @(posedge clk_i) begin
    in_taken <= rst_ni && in_valid_i && !in_stall_o;
    if (rst_ni && in_valid_i && !in_stall_o) begin
      morph_step(operation_i, pixel_in_i);
    end
  end

  always @(negedge clk_i) begin
    if (rst_ni && (!in_valid_i || in_taken)) begin
      if (send_gap > 0) begin
        send_gap--;
        in_valid_i <= 1'b0;
      end else if (!no_idle && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 15);
        in_valid_i <= 1'b0;
      end else if (raster_q.size() != 0) begin
        next_item = raster_q.pop_front();
        operation_i <= next_item.op;
        pixel_in_i  <= next_item.pix;
        in_valid_i  <= 1'b1;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // Output side: random stall bursts plus one long hold-off.
  always @(negedge clk_i) begin
    if (hold_req && !hold_done) begin
      hold_done = 1'b1;
      hold_left = HOLD_CYCLES;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (no_idle) begin
      out_stall_i <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 15);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    morph_out_t exp_px;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (due_pixels.size() == 0) begin
        flag_error($sformatf("unexpected transaction pixel_out %0d frame_end %0b",
                             pixel_out_o, frame_end_o));
      end else begin
        exp_px = due_pixels.pop_front();
        if (exp_px.pix !== pixel_out_o || exp_px.fend !== frame_end_o) begin
          flag_error($sformatf(
            "pixel_out expected %0d got %0d, frame_end expected %0b got %0b",
            exp_px.pix, pixel_out_o, exp_px.fend, frame_end_o));
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i)) begin
      quiet_cycles = 0;
    end else if (quiet_cycles >= STUCK_LIMIT) begin
      $display("binary_morphology_3x3 test failed");
      $finish;
    end else begin
      quiet_cycles++;
    end
  end

  initial begin
    int                w;
    int                h;
    int                n;
    int                phase;
    int                big_items;
    logic [31:0]       wreg;
    logic [31:0]       hreg;
    logic [MASK_W-1:0] mask;
    logic [8:0]        opening [22];

    foreach (row_old[i]) begin
      row_old[i] = '0;
      row_new[i] = '0;
    end
    foreach (win[r, c]) win[r][c] = '0;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    reg_read_check(REG_MODE, RST_MODE);
    reg_read_check(REG_MASK, RST_MASK);
    reg_read_check(REG_WIDTH, RST_WIDTH);
    reg_read_check(REG_HEIGHT, RST_HEIGHT);

    // Directed: clamped 3x3 frame, unused mode, ignored drains, mid-frame
    // flush abandoned by a pixel, non-binary pixels, full flush.
    reg_set(REG_WIDTH, 32'd0);
    reg_set(REG_HEIGHT, 32'd2);
    reg_set(REG_MODE, 32'd7);
    reg_set(REG_MASK, RST_MASK);
    opening = '{{OP_DRAIN, 8'hA5},
                {OP_PIXEL, PIX_BG}, {OP_PIXEL, PIX_FG}, {OP_PIXEL, 8'd7},
                {OP_PIXEL, PIX_FG}, {OP_PIXEL, PIX_FG}, {OP_PIXEL, 8'd128},
                {OP_DRAIN, 8'h5A},
                {OP_PIXEL, PIX_FG}, {OP_PIXEL, PIX_FG}, {OP_PIXEL, PIX_FG},
                {OP_PIXEL, PIX_FG}, {OP_PIXEL, PIX_FG}, {OP_PIXEL, PIX_FG},
                {OP_PIXEL, PIX_BG}, {OP_PIXEL, PIX_FG}, {OP_PIXEL, PIX_FG},
                {OP_DRAIN, 8'hFF}, {OP_DRAIN, 8'h00}, {OP_DRAIN, 8'h81},
                {OP_DRAIN, 8'h7E}, {OP_DRAIN, 8'hC3}};
    foreach (opening[i]) push_item(opening[i][8], opening[i][7:0]);
    settle(1'b1);

    phase = 0;
    big_items = 0;
    items_queued = 0;
    while (items_queued - big_items < ITEMS_GOAL) begin
      if (items_queued - big_items > ITEMS_GOAL - 200) no_idle = 1'b1;

      case (phase % 5)
        0:       mask = RST_MASK;
        1:       mask = '1;
        2:       mask = '0;
        default: begin
          mask = MASK_W'($urandom);
          if ($urandom_range(0, 1) == 1) mask[9:8] = CODE_FG;
        end
      endcase

      if (phase == 3) begin
        wreg = 32'd2047;
      end else begin
        case ($urandom_range(0, 9))
          0:       wreg = $urandom_range(0, 2);
          1:       wreg = 32'd3;
          default: wreg = $urandom_range(3, 8);
        endcase
      end
      case ($urandom_range(0, 11))
        0:       hreg = $urandom_range(0, 2);
        1:       hreg = 32'd1024;
        2:       hreg = 32'd2047;
        default: hreg = $urandom_range(3, 6);
      endcase

      reg_set(REG_MODE, 32'(phase % 8));
      reg_set(REG_MASK, 32'(mask));
      reg_set(REG_WIDTH, wreg);
      reg_set(REG_HEIGHT, hreg);
      fg_pct = $urandom_range(20, 90);

      w = eff_size(wreg[SIZE_W-1:0], MAX_W);
      h = eff_size(hreg[SIZE_W-1:0], MAX_H);
      if (phase == 3) n = w + 10;
      else if (phase == 2) n = 200;
      else if (w * h > 100) n = 2 * w + $urandom_range(0, 20);
      else n = $urandom_range(1, 3) * w * h;
      if (phase == 3) big_items = n;

      for (int i = 0; i < n; i++) begin
        if (phase != 3 && $urandom_range(0, 39) == 0) begin
          repeat ($urandom_range(1, w + 1)) push_item(OP_DRAIN, 8'($urandom_range(0, 255)));
        end else begin
          push_item(OP_PIXEL, rand_pix());
        end
      end
      if (phase == 2) hold_req = 1'b1;

      // Leave the wide frame mid-stream: the next, narrower size wraps it.
      settle(phase != 3);
      phase++;
    end

    wait_idle();
    repeat (20) @(posedge clk_i);
    if (errors == 0) begin
      $display("binary_morphology_3x3 test passed");
    end else begin
      $display("binary_morphology_3x3 test failed");
    end
    $finish;
  end

endmodule
